[src/mp2d_pkg.sv]
// Shared constants, register codes and the stride reciprocal table for max_pooling_2d.
// Has no dependencies. The top level and the testbench read it by scoped names.
`default_nettype none

package mp2d_pkg;

  localparam int DataW     = 8;
  localparam int CfgDimW   = 11;
  localparam int CfgWinW   = 3;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 11;
  localparam int OutCoordW = 10;
  localparam int MaxHeight = 1024;
  localparam int RowW      = 10;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxWindow = 4;

  localparam logic [CfgDimW-1:0] ResetImageWidth  = CfgDimW'(64);
  localparam logic [CfgDimW-1:0] ResetImageHeight = CfgDimW'(64);
  localparam logic [CfgWinW-1:0] ResetWindowSize  = CfgWinW'(2);
  localparam logic [CfgWinW-1:0] ResetStride      = CfgWinW'(2);

  // Division by a stride of 1..7 is a multiply by ceil(2^RecipShift / stride).
  // Exact for dividends below 4096.
  localparam int RecipShift = 18;
  localparam int RecipW     = RecipShift + 1;

  localparam logic [RecipW-1:0] Recip1 = RecipW'((2 ** RecipShift) / 1);
  localparam logic [RecipW-1:0] Recip2 = RecipW'((2 ** RecipShift + 1) / 2);
  localparam logic [RecipW-1:0] Recip3 = RecipW'((2 ** RecipShift + 2) / 3);
  localparam logic [RecipW-1:0] Recip4 = RecipW'((2 ** RecipShift + 3) / 4);
  localparam logic [RecipW-1:0] Recip5 = RecipW'((2 ** RecipShift + 4) / 5);
  localparam logic [RecipW-1:0] Recip6 = RecipW'((2 ** RecipShift + 5) / 6);
  localparam logic [RecipW-1:0] Recip7 = RecipW'((2 ** RecipShift + 6) / 7);

  typedef enum logic [CfgAddrW-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1,
    RegWindowSize  = 2'd2,
    RegStride      = 2'd3
  } cfg_reg_e;

  // A stride of zero acts as one.
  function automatic logic [RecipW-1:0] stride_recip(input logic [CfgWinW-1:0] st);
    logic [RecipW-1:0] r;
    unique case (st)
      3'd0, 3'd1: r = Recip1;
      3'd2:       r = Recip2;
      3'd3:       r = Recip3;
      3'd4:       r = Recip4;
      3'd5:       r = Recip5;
      3'd6:       r = Recip6;
      3'd7:       r = Recip7;
      default:    r = Recip1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/mp2d_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read during a write to the same address returns the old contents. No dependencies.
`default_nettype none

module mp2d_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/max_pooling_2d.sv]
// Streaming 2-D max pooling of 8-bit grey pixels in raster order.
// A pixel's result is registered in stage 1 and then in the output register.
// Throughput: one pixel per cycle unless the output stalls; one column word of all
// line stores is read and written per pixel in the single line store RAM (mp2d_ram).
// Reset: counters and column maxima clear, registers return to 64/64/2/2;
// line store contents stay undefined, with no clearing pass.
`default_nettype none

module max_pooling_2d #(
  parameter int MAX_WIDTH  = mp2d_pkg::DefMaxWidth,
  parameter int MAX_WINDOW = mp2d_pkg::DefMaxWindow
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mp2d_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [mp2d_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [mp2d_pkg::DataW-1:0]       pixel_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [mp2d_pkg::DataW-1:0]       pooled_value_o,
  output logic      [mp2d_pkg::OutCoordW-1:0]   out_col_o,
  output logic      [mp2d_pkg::OutCoordW-1:0]   out_row_o,
  output logic                                  frame_last_o
);

  localparam int DataW  = mp2d_pkg::DataW;
  localparam int RowW   = mp2d_pkg::RowW;
  localparam int DimW   = mp2d_pkg::CfgDimW;
  localparam int WinW   = mp2d_pkg::CfgWinW;
  localparam int RecipW = mp2d_pkg::RecipW;
  localparam int Shift  = mp2d_pkg::RecipShift;
  localparam int Lines  = MAX_WINDOW - 1;
  localparam int CntW   = $clog2(MAX_WIDTH);
  localparam int WLimW  = (CntW + 1 > DimW) ? CntW + 1 : DimW;
  localparam int PtrW   = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int WordW  = DataW * Lines;
  localparam int HgtW   = DimW;

  typedef struct packed {
    logic [DataW-1:0] px;
    logic [CntW-1:0]  col;
    logic [PtrW-1:0]  ptr;
    logic [Lines-1:0] use_line;
    logic             emit;
    logic             last;
    logic [CntW-1:0]  xcol;
    logic [RowW-1:0]  xrow;
  } s1_t;

  // configuration
  logic [DimW-1:0] img_w_q, img_h_q;
  logic [WinW-1:0] win_q, stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= mp2d_pkg::ResetImageWidth;
      img_h_q  <= mp2d_pkg::ResetImageHeight;
      win_q    <= mp2d_pkg::ResetWindowSize;
      stride_q <= mp2d_pkg::ResetStride;
    end else if (cfg_we_i) begin
      unique case (mp2d_pkg::cfg_reg_e'(cfg_addr_i))
        mp2d_pkg::RegImageWidth:  img_w_q  <= cfg_wdata_i[DimW-1:0];
        mp2d_pkg::RegImageHeight: img_h_q  <= cfg_wdata_i[DimW-1:0];
        mp2d_pkg::RegWindowSize:  win_q    <= cfg_wdata_i[WinW-1:0];
        mp2d_pkg::RegStride:      stride_q <= cfg_wdata_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  // effective configuration
  logic [WLimW-1:0] w_eff;
  logic [HgtW-1:0]  h_eff;
  logic [WinW-1:0]  ws, ws_m1, st;
  logic             ws_ok;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = WLimW'(1);
    end else if (WLimW'(img_w_q) > WLimW'(MAX_WIDTH)) begin
      w_eff = WLimW'(MAX_WIDTH);
    end else begin
      w_eff = WLimW'(img_w_q);
    end
    if (img_h_q == '0) begin
      h_eff = HgtW'(1);
    end else if (img_h_q > HgtW'(mp2d_pkg::MaxHeight)) begin
      h_eff = HgtW'(mp2d_pkg::MaxHeight);
    end else begin
      h_eff = img_h_q;
    end
    ws    = (win_q == '0) ? WinW'(1) : win_q;
    st    = (stride_q == '0) ? WinW'(1) : stride_q;
    ws_m1 = ws - WinW'(1);
    ws_ok = int'(ws) <= MAX_WINDOW;
  end

  // position counters
  logic [CntW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            col_wrap, row_zero;
  logic [HgtW-1:0] row_inc;

  logic in_accept, s1_valid_q, s1_adv;
  s1_t  s1_q, s1_d;

  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    col_wrap = (WLimW'(col_q) + WLimW'(1)) >= w_eff;
    col_d    = col_wrap ? '0 : col_q + CntW'(1);
    row_inc  = col_wrap ? HgtW'(row_q) + HgtW'(1) : HgtW'(row_q);
    row_zero = row_inc >= h_eff;
    row_d    = row_zero ? '0 : row_inc[RowW-1:0];
    if (row_zero) begin
      ptr_d = '0;
    end else if (col_wrap) begin
      ptr_d = (ptr_q == PtrW'(Lines - 1)) ? '0 : ptr_q + PtrW'(1);
    end else begin
      ptr_d = ptr_q;
    end
  end

  // stage 0: decide which lines take part and whether a window completes
  always_comb begin
    s1_d.px  = pixel_i;
    s1_d.col = col_q;
    s1_d.ptr = ptr_q;
    for (int k = 1; k <= Lines; k++) begin
      s1_d.use_line[k-1] = (!ws_ok || k < int'(ws)) && int'(row_q) >= k;
    end
    s1_d.emit = ws_ok && WLimW'(ws) <= w_eff && HgtW'(ws) <= h_eff &&
                WLimW'(col_q) < w_eff && HgtW'(row_q) < h_eff &&
                WLimW'(col_q) >= WLimW'(ws_m1) && HgtW'(row_q) >= HgtW'(ws_m1);
    s1_d.last = (WLimW'(col_q) + WLimW'(st)) >= w_eff &&
                (HgtW'(row_q) + HgtW'(st)) >= h_eff;
    s1_d.xcol = col_q - CntW'(ws_m1);
    s1_d.xrow = row_q - RowW'(ws_m1);
  end

  // line store RAM: one word per column holding all lines
  logic             ram_we;
  logic [WordW-1:0] ram_rdata, ram_wdata;
  logic             fwd_q;
  logic [WordW-1:0] fwd_word_q;

  mp2d_ram #(
    .Width (WordW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.col),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // stage 1: merge line data, update column maxima, form the result
  logic [WordW-1:0]      word;
  logic [DataW-1:0]      vmax, pool_max;
  logic [DataW-1:0]      lane;
  logic [PtrW-1:0]       idx;
  logic [DataW-1:0]      cmax_q [Lines];
  logic [CntW+RecipW-1:0] prod_col;
  logic [RowW+RecipW-1:0] prod_row;
  logic [RecipW-1:0]     recip;
  logic                  div_col, div_row, s1_emit;
  logic                  out_valid_q;

  always_comb begin
    word = fwd_q ? fwd_word_q : ram_rdata;
    vmax = s1_q.px;
    for (int k = 1; k <= Lines; k++) begin
      idx  = (int'(s1_q.ptr) >= k) ? s1_q.ptr - PtrW'(k) : PtrW'(int'(s1_q.ptr) + Lines - k);
      lane = word[idx*DataW +: DataW];
      if (s1_q.use_line[k-1] && lane > vmax) begin
        vmax = lane;
      end
    end
    for (int i = 0; i < Lines; i++) begin
      ram_wdata[i*DataW +: DataW] = (PtrW'(i) == s1_q.ptr) ? s1_q.px : word[i*DataW +: DataW];
    end
    pool_max = vmax;
    for (int k = 1; k < MAX_WINDOW; k++) begin
      if (k < int'(ws) && cmax_q[k-1] > pool_max) begin
        pool_max = cmax_q[k-1];
      end
    end
  end

  assign recip    = mp2d_pkg::stride_recip(stride_q);
  assign prod_col = (CntW+RecipW)'(s1_q.xcol) * (CntW+RecipW)'(recip);
  assign prod_row = (RowW+RecipW)'(s1_q.xrow) * (RowW+RecipW)'(recip);
  assign div_col  = prod_col[Shift-1:0] < recip[Shift-1:0] || recip[Shift];
  assign div_row  = prod_row[Shift-1:0] < recip[Shift-1:0] || recip[Shift];
  assign s1_emit  = s1_q.emit && div_col && div_row;
  assign s1_adv   = s1_valid_q && (!s1_emit || !out_valid_q || out_ready_i);
  assign ram_we   = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      ptr_q       <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Lines; i++) begin
        cmax_q[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        ptr_q      <= ptr_d;
        s1_valid_q <= 1'b1;
        // same column written back at this edge: the RAM still returns old data
        fwd_q      <= s1_adv && (s1_q.col == col_q);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
      if (s1_adv) begin
        cmax_q[0] <= vmax;
        for (int i = 1; i < Lines; i++) begin
          cmax_q[i] <= cmax_q[i-1];
        end
      end
      if (s1_adv && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q       <= s1_d;
      fwd_word_q <= ram_wdata;
    end
    if (s1_adv && s1_emit) begin
      pooled_value_o <= pool_max;
      out_col_o      <= mp2d_pkg::OutCoordW'(prod_col[Shift +: CntW]);
      out_row_o      <= mp2d_pkg::OutCoordW'(prod_row[Shift +: RowW]);
      frame_last_o   <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;

  // forwarded word only belongs to an item held in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni) fwd_q |-> s1_valid_q)
    else $error("forward flag set with stage 1 empty");

  // line pointer follows the row counter
  assert property (@(posedge clk_i) disable iff (!rst_ni) (row_q == '0) |-> (ptr_q == '0))
    else $error("line pointer out of step with row counter");

  assert property (@(posedge clk_i) disable iff (!rst_ni) int'(ptr_q) < Lines)
    else $error("line pointer beyond line count");

  // a stalled stage 1 item keeps its column and holds off new pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> ($stable(s1_q.col) && s1_valid_q))
    else $error("stage 1 item changed while stalled");

  // a result leaves stage 1 only into a free or draining output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_emit && out_valid_q) |-> out_ready_i)
    else $error("output register overwritten");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for max_pooling_2d: streams pixel frames under changing
// register settings and checks every pooled result against a behavioral predictor.
// Depends on mp2d_pkg and the max_pooling_2d RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DataW        = mp2d_pkg::DataW;
  localparam int OutCoordW    = mp2d_pkg::OutCoordW;
  localparam int CfgAddrW     = mp2d_pkg::CfgAddrW;
  localparam int CfgDataW     = mp2d_pkg::CfgDataW;
  localparam int CfgDimW      = mp2d_pkg::CfgDimW;
  localparam int CfgWinW      = mp2d_pkg::CfgWinW;
  localparam int DefMaxWidth  = mp2d_pkg::DefMaxWidth;
  localparam int DefMaxWindow = mp2d_pkg::DefMaxWindow;
  localparam int MaxHeight    = mp2d_pkg::MaxHeight;

  localparam int LineCount   = DefMaxWindow - 1;
  localparam int CycleLimit  = 800_000;
  localparam int RandomItems = 1320;

  typedef struct packed {
    logic [DataW-1:0]     value;
    logic [OutCoordW-1:0] col;
    logic [OutCoordW-1:0] row;
    logic                 last;
  } pool_res_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DataW-1:0]     pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DataW-1:0]     pooled_value;
  logic [OutCoordW-1:0] out_col;
  logic [OutCoordW-1:0] out_row;
  logic                 frame_last;

  // Predictor copy of registers, line stores, column maxima and position.
  logic [CfgDimW-1:0] reg_width  = mp2d_pkg::ResetImageWidth;
  logic [CfgDimW-1:0] reg_height = mp2d_pkg::ResetImageHeight;
  logic [CfgWinW-1:0] reg_window = mp2d_pkg::ResetWindowSize;
  logic [CfgWinW-1:0] reg_stride = mp2d_pkg::ResetStride;
  logic [DataW-1:0]   line_mem [LineCount][DefMaxWidth];
  logic [DataW-1:0]   col_maxima [DefMaxWindow] = '{default: '0};
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  logic [DataW-1:0] pixel_q [$];
  pool_res_t        expected_q [$];
  int               idle_pct = 20;
  int unsigned      error_count = 0;
  int unsigned      pixels_accepted = 0;
  int unsigned      results_checked = 0;
  int unsigned      reg_writes = 0;
  int unsigned      random_frames = 0;
  int unsigned      cycle_count = 0;

  max_pooling_2d u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_i        (pixel),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pooled_value_o (pooled_value),
    .out_col_o      (out_col),
    .out_row_o      (out_row),
    .frame_last_o   (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    return (reg_width > DefMaxWidth) ? DefMaxWidth : reg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height == 0) return 1;
    return (reg_height > MaxHeight) ? MaxHeight : reg_height;
  endfunction

  // Advance the predictor by one pixel; return 1 when a window completes.
  function automatic bit pool_pixel(input logic [DataW-1:0] px, output pool_res_t res);
    int unsigned w, h, ws, st, wsr, c, r, k, oc, orow;
    logic [DataW-1:0] vmax, best;
    bit ws_ok, hit;
    res = '0;
    w = eff_width();
    h = eff_height();
    ws = (reg_window == 0) ? 1 : reg_window;
    st = (reg_stride == 0) ? 1 : reg_stride;
    ws_ok = ws <= DefMaxWindow;
    wsr = ws_ok ? ws : DefMaxWindow;
    c = col_pos % DefMaxWidth;
    r = row_pos;
    vmax = px;
    for (k = 1; k < wsr; k++)
      if (r >= k && line_mem[(r - k) % LineCount][c] > vmax)
        vmax = line_mem[(r - k) % LineCount][c];
    for (k = DefMaxWindow - 1; k > 0; k--) col_maxima[k] = col_maxima[k - 1];
    col_maxima[0] = vmax;
    line_mem[r % LineCount][c] = px;
    hit = ws_ok && ws <= w && ws <= h && col_pos < w && r < h &&
          col_pos >= ws - 1 && r >= ws - 1 &&
          (col_pos - (ws - 1)) % st == 0 && (r - (ws - 1)) % st == 0;
    if (hit) begin
      best = col_maxima[0];
      for (k = 1; k < ws; k++)
        if (col_maxima[k] > best) best = col_maxima[k];
      oc = (col_pos - (ws - 1)) / st;
      orow = (r - (ws - 1)) / st;
      res.value = best;
      res.col = OutCoordW'(oc);
      res.row = OutCoordW'(orow);
      res.last = (oc == (w - ws) / st) && (orow == (h - ws) / st);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end else if (row_pos >= h) begin
      row_pos = 0;
    end
    return hit;
  endfunction

  // Pixels still needed to bring the position back to the frame origin.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, c, r, n;
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    n = 0;
    do begin
      c++;
      n++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end else if (r >= h) begin
        r = 0;
      end
    end while (c != 0 || r != 0);
    return n;
  endfunction

  function automatic int unsigned random_setting(mp2d_pkg::cfg_reg_e which);
    int unsigned sel;
    sel = $urandom_range(19);
    case (which)
      mp2d_pkg::RegImageWidth: begin
        if (sel == 0) return 0;
        if (sel < 3) return $urandom_range(64, 13);
        return $urandom_range(12, 1);
      end
      mp2d_pkg::RegImageHeight: begin
        if (sel == 0) return 0;
        return $urandom_range(10, 1);
      end
      default: begin
        if (sel < 3) return $urandom_range(7);
        return $urandom_range(4, 1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
    error_count++;
    if (error_count <= 40)
      $display("[%0t] %s: got %0d, expected %0d (result %0d)",
               $time, what, got_v, want_v, results_checked);
  endtask

  task automatic push_pixels(int unsigned n);
    repeat (n) begin
      case ($urandom_range(7))
        0:       pixel_q.push_back(8'h00);
        1:       pixel_q.push_back(8'hFF);
        default: pixel_q.push_back(DataW'($urandom_range(255)));
      endcase
    end
  endtask

  // Hold until every pixel is in and every pooled value is back.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(mp2d_pkg::cfg_reg_e which, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= which;
    cfg_wdata <= CfgDataW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      mp2d_pkg::RegImageWidth:  reg_width  = CfgDimW'(value);
      mp2d_pkg::RegImageHeight: reg_height = CfgDimW'(value);
      mp2d_pkg::RegWindowSize:  reg_window = CfgWinW'(value);
      mp2d_pkg::RegStride:      reg_stride = CfgWinW'(value);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned ws, int unsigned st);
    wait_idle();
    write_reg(mp2d_pkg::RegImageWidth, w);
    write_reg(mp2d_pkg::RegImageHeight, h);
    write_reg(mp2d_pkg::RegWindowSize, ws);
    write_reg(mp2d_pkg::RegStride, st);
  endtask

  // Pixel sender: one transaction per pending pixel, with random idle bursts.
  always @(posedge clk or negedge rst_n) begin : driver
    int unsigned gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      pixel <= '0;
      gap = 0;
    end else if (!in_valid || in_ready) begin
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0 && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        gap = $urandom_range(13);
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        pixel <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on each pixel transaction, check each result transaction, stall the output.
  always @(posedge clk or negedge rst_n) begin : monitor
    int unsigned gap;
    pool_res_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        pixels_accepted++;
        if (pool_pixel(pixel, want)) expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {pooled_value, out_col, out_row, frame_last};
        results_checked++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no window pending", got.value, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.value != want.value) report_mismatch("pooled_value", got.value, want.value);
          if (got.col != want.col) report_mismatch("out_col", got.col, want.col);
          if (got.row != want.row) report_mismatch("out_row", got.row, want.row);
          if (got.last != want.last) report_mismatch("frame_last", got.last, want.last);
        end
      end
      if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(299) < idle_pct) begin
        gap = $urandom_range(13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_q.size());
    $display("** max_pooling_2d: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned n, part, random_items, frame_no;
    bit big;
    mp2d_pkg::cfg_reg_e which;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Fill all three line stores across 64 columns under reset settings, so no
    // later frame of that width or less can read an unwritten entry.
    push_pixels(3 * 64);
    wait_idle();
    // Cut the height below the current row, then the width, in mid-frame.
    write_reg(mp2d_pkg::RegImageHeight, 3);
    write_reg(mp2d_pkg::RegImageWidth, 2);
    push_pixels(pixels_to_frame_end());
    // Zero settings act as a 1x1 frame with unit window and stride.
    configure(0, 0, 0, 0);
    pixel_q.push_back(8'h00);
    pixel_q.push_back(8'hFF);
    // Window larger than the frame, then window beyond the maximum: no output.
    configure(2, 2, 3, 1);
    push_pixels(4);
    configure(2, 2, 7, 1);
    push_pixels(4);
    // Stride wider than the frame leaves a single window.
    configure(3, 2, 2, 7);
    push_pixels(6);
    // Narrow the width below the current column in mid-frame.
    configure(4, 4, 2, 1);
    push_pixels(7);
    wait_idle();
    write_reg(mp2d_pkg::RegImageWidth, 2);
    push_pixels(pixels_to_frame_end());

    random_items = 0;
    frame_no = 0;
    while (random_items < RandomItems) begin
      frame_no++;
      big = (frame_no == 2);
      // A saturated one-row frame sweeps the full column range.
      if (big) configure(2047, 1, 1, 1);
      else if (frame_no == 3 || $urandom_range(3) != 0)
        configure(random_setting(mp2d_pkg::RegImageWidth),
                  random_setting(mp2d_pkg::RegImageHeight),
                  random_setting(mp2d_pkg::RegWindowSize),
                  random_setting(mp2d_pkg::RegStride));
      n = eff_width() * eff_height();
      if (random_items + n > RandomItems - 300) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(4))
          0:       idle_pct = 0;
          1:       idle_pct = 8;
          3:       idle_pct = 40;
          default: idle_pct = 20;
        endcase
      end
      if (!big && n > 1 && $urandom_range(6) == 0) begin
        part = $urandom_range(n - 1, 1);
        push_pixels(part);
        // Hold the sender until every result is back, then retune one register.
        wait_idle();
        which = mp2d_pkg::cfg_reg_e'($urandom_range(3));
        write_reg(which, random_setting(which));
        n = part + pixels_to_frame_end();
        push_pixels(n - part);
      end else begin
        push_pixels(n);
      end
      random_items += n;
      random_frames++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Streamed %0d pixels (%0d random frames), checked %0d pooled results,",
             pixels_accepted, random_frames, results_checked);
    $display("%0d reg writes; zero, saturated and oversized settings, retuning, stalls",
             reg_writes);
    if (error_count == 0) $display("** max_pooling_2d: PASSED **");
    else $display("** max_pooling_2d: FAILED **");
    $finish;
  end

endmodule
